// ===== rtl/core/mnet_pkg.sv =====
// Shared types, constants and register codes for the MIDI note event tracker.
package mnet_pkg;

  localparam int NUM_TRACKS      = 3;
  localparam int NUM_DRUM_VOICES = 4;
  localparam int NOTE_COUNT      = 128;
  localparam int NOTE_W          = 7;
  localparam int CH_W            = 5;
  localparam int DRUM_IDX_W      = 2;
  localparam int DRUM_BASE_NOTE  = 48;
  localparam int OUT_COUNT_W     = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

  localparam logic [CH_W-1:0] DRUM_CH_RESET = 5'd10;
  localparam logic [7:0]      NO_NOTE       = 8'hFF;

  typedef enum logic [2:0] {
    REG_DRUM_CH0 = 3'd0,
    REG_DRUM_CH1 = 3'd1,
    REG_DRUM_CH2 = 3'd2,
    REG_DRUM_CH3 = 3'd3,
    REG_MEL_CH1  = 3'd4,
    REG_MEL_CH2  = 3'd5,
    REG_MEL_CH3  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [NUM_DRUM_VOICES-1:0][CH_W-1:0] drum_ch;
    logic [NUM_TRACKS-1:0][CH_W-1:0]      mel_ch;
  } cfg_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [NOTE_W-1:0] note;
  } lane_cmd_t;

endpackage

// ===== rtl/core/midi_note_event_tracker_unit.sv =====
// Top level of the MIDI note event tracker: input stage, drum logic, tracks, result stage.
//
//   channel | direction | handshake          | payload
//   in      | into      | in_valid/in_stall   | status_byte, note_number, velocity
//   out     | out of    | out_valid/out_stall | drum and track results
//   cfg     | into      | APB psel/penable    | channel registers 0..6 at 4*i
//
// An input beat is registered, then decoded and applied to the bitmaps and counters while
// the result register loads the result beat. One beat per cycle is sustained while the
// output does not stall; the 128-bit highest-note encoder sets the cycle time.
// Reset clears all bitmaps and counters at once and loads the default channels.
// A stall on the output holds the result register and then backs up into in_stall.
module midi_note_event_tracker_unit #(
  parameter int COUNT_WIDTH = mnet_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mnet_pkg::ADDR_W-1:0] paddr,
  input  logic [mnet_pkg::DATA_W-1:0] pwdata,
  output logic [mnet_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  status_byte,
  input  logic [6:0]                  note_number,
  input  logic [6:0]                  velocity,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        drum_hit,
  output logic [1:0]                  drum_voice,
  output logic [31:0]                 drum_voice_count,
  output logic [31:0]                 drum_total_count,
  output logic [2:0]                  track_note_on_mask,
  output logic signed [7:0]           highest_note_1,
  output logic signed [7:0]           highest_note_2,
  output logic signed [7:0]           highest_note_3,
  output logic [31:0]                 note_on_count_1,
  output logic [31:0]                 note_on_count_2,
  output logic [31:0]                 note_on_count_3
);
  import mnet_pkg::*;

  cfg_t cfg;

  // Input stage.
  logic              s1_valid;
  logic [7:0]        s1_status;
  logic [NOTE_W-1:0] s1_note;
  logic [NOTE_W-1:0] s1_vel;
  logic              advance;
  logic              in_take;

  // Decode.
  logic [CH_W-1:0] ch;
  logic            is_on;
  logic            is_off;
  logic [NUM_DRUM_VOICES-1:0] drum_match;
  logic            hit;
  logic [DRUM_IDX_W-1:0] voice;

  // Counters.
  logic [NUM_DRUM_VOICES-1:0][COUNT_WIDTH-1:0] drum_cnt;
  logic [COUNT_WIDTH-1:0] voice_cnt_next;
  logic [COUNT_WIDTH-1:0] total_cnt;
  logic [COUNT_WIDTH-1:0] total_cnt_next;

  lane_cmd_t [NUM_TRACKS-1:0]             lane_cmd;
  logic [NUM_TRACKS-1:0][7:0]             lane_high;
  logic [NUM_TRACKS-1:0][COUNT_WIDTH-1:0] lane_cnt;
  logic [NUM_TRACKS-1:0]                  on_mask;

  mnet_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_status <= status_byte;
      s1_note   <= note_number;
      s1_vel    <= velocity;
    end
  end

  assign ch     = {1'b0, s1_status[3:0]} + 1'b1;
  assign is_on  = (s1_status[7:4] == KIND_NOTE_ON) && (s1_vel != '0);
  assign is_off = (s1_status[7:4] == KIND_NOTE_OFF) ||
                  ((s1_status[7:4] == KIND_NOTE_ON) && (s1_vel == '0));

  always_comb begin
    for (int v = 0; v < NUM_DRUM_VOICES; v++) begin
      drum_match[v] = is_on && (ch == cfg.drum_ch[v]) &&
                      (s1_note == NOTE_W'(DRUM_BASE_NOTE + 2 * v));
    end
  end

  // The lowest matching voice wins.
  always_comb begin
    voice = '0;
    for (int v = NUM_DRUM_VOICES - 1; v >= 0; v--) begin
      if (drum_match[v]) begin
        voice = DRUM_IDX_W'(v);
      end
    end
  end

  assign hit            = |drum_match;
  assign voice_cnt_next = drum_cnt[voice] + 1'b1;
  assign total_cnt_next = hit ? total_cnt + 1'b1 : total_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      drum_cnt  <= '0;
      total_cnt <= '0;
    end else if (advance && hit) begin
      drum_cnt[voice] <= voice_cnt_next;
      total_cnt       <= total_cnt_next;
    end
  end

  for (genvar t = 0; t < NUM_TRACKS; t++) begin : g_lane
    logic chan_match;
    assign chan_match       = advance && !hit && (ch == cfg.mel_ch[t]);
    assign lane_cmd[t].set  = chan_match && is_on;
    assign lane_cmd[t].clr  = chan_match && is_off;
    assign lane_cmd[t].note = s1_note;
    assign on_mask[t]       = lane_cmd[t].set;

    mnet_track_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk          (clk),
      .rst          (rst),
      .cmd          (lane_cmd[t]),
      .highest_next (lane_high[t]),
      .count_next   (lane_cnt[t])
    );
  end

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drum_hit           <= hit;
      drum_voice         <= voice;
      drum_voice_count   <= hit ? OUT_COUNT_W'(voice_cnt_next) : '0;
      drum_total_count   <= OUT_COUNT_W'(total_cnt_next);
      track_note_on_mask <= on_mask;
      highest_note_1     <= lane_high[0];
      highest_note_2     <= lane_high[1];
      highest_note_3     <= lane_high[2];
      note_on_count_1    <= OUT_COUNT_W'(lane_cnt[0]);
      note_on_count_2    <= OUT_COUNT_W'(lane_cnt[1]);
      note_on_count_3    <= OUT_COUNT_W'(lane_cnt[2]);
    end
  end

  a_hit_excludes_tracks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drum_hit && (track_note_on_mask != '0)))
    else $error("drum hit reported together with a track note-on");

  a_no_hit_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !drum_hit) |-> (drum_voice == '0 && drum_voice_count == '0))
    else $error("voice fields nonzero without a drum hit");

  a_total_steps: assert property (@(posedge clk) disable iff (rst)
    (advance && hit) |=> (total_cnt == $past(total_cnt) + 1'b1))
    else $error("drum total did not step on a hit");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked item");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after advance");

endmodule

// ===== rtl/core/mnet_cfg_regs.sv =====
// APB register file holding the drum and melodic channel assignments.
module mnet_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mnet_pkg::ADDR_W-1:0] paddr,
  input  logic [mnet_pkg::DATA_W-1:0] pwdata,
  output logic [mnet_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mnet_pkg::cfg_t              cfg
);
  import mnet_pkg::*;

  logic     wr_en;
  reg_idx_t idx;
  logic [CH_W-1:0] rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < NUM_DRUM_VOICES; v++) begin
        cfg.drum_ch[v] <= DRUM_CH_RESET;
      end
      for (int t = 0; t < NUM_TRACKS; t++) begin
        cfg.mel_ch[t] <= CH_W'(t + 2);
      end
    end else if (wr_en) begin
      case (idx)
        REG_DRUM_CH0: cfg.drum_ch[0] <= pwdata[CH_W-1:0];
        REG_DRUM_CH1: cfg.drum_ch[1] <= pwdata[CH_W-1:0];
        REG_DRUM_CH2: cfg.drum_ch[2] <= pwdata[CH_W-1:0];
        REG_DRUM_CH3: cfg.drum_ch[3] <= pwdata[CH_W-1:0];
        REG_MEL_CH1:  cfg.mel_ch[0]  <= pwdata[CH_W-1:0];
        REG_MEL_CH2:  cfg.mel_ch[1]  <= pwdata[CH_W-1:0];
        REG_MEL_CH3:  cfg.mel_ch[2]  <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DRUM_CH0: rd_val = cfg.drum_ch[0];
      REG_DRUM_CH1: rd_val = cfg.drum_ch[1];
      REG_DRUM_CH2: rd_val = cfg.drum_ch[2];
      REG_DRUM_CH3: rd_val = cfg.drum_ch[3];
      REG_MEL_CH1:  rd_val = cfg.mel_ch[0];
      REG_MEL_CH2:  rd_val = cfg.mel_ch[1];
      REG_MEL_CH3:  rd_val = cfg.mel_ch[2];
      default:      rd_val = '0;
    endcase
  end

  assign prdata = {{(DATA_W-CH_W){1'b0}}, rd_val};

endmodule

// ===== rtl/core/mnet_track_lane.sv =====
// One melodic track: held-note bitmap, note-on counter and highest-note encoder.
module mnet_track_lane #(
  parameter int COUNT_WIDTH = mnet_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mnet_pkg::lane_cmd_t    cmd,
  output logic [7:0]             highest_next,
  output logic [COUNT_WIDTH-1:0] count_next
);
  import mnet_pkg::*;

  logic [NOTE_COUNT-1:0]  bits;
  logic [NOTE_COUNT-1:0]  bits_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [NOTE_W-1:0]      top_idx;
  logic [63:0] w6;
  logic [31:0] w5;
  logic [15:0] w4;
  logic [7:0]  w3;
  logic [3:0]  w2;
  logic        w1;

  always_comb begin
    bits_next = bits;
    if (cmd.set) begin
      bits_next[cmd.note] = 1'b1;
    end else if (cmd.clr) begin
      bits_next[cmd.note] = 1'b0;
    end
  end

  assign count_next = cmd.set ? count + 1'b1 : count;

  // Binary search for the highest set bit, one index bit per level.
  always_comb begin
    top_idx[6] = |bits_next[127:64];
    w6 = top_idx[6] ? bits_next[127:64] : bits_next[63:0];
    top_idx[5] = |w6[63:32];
    w5 = top_idx[5] ? w6[63:32] : w6[31:0];
    top_idx[4] = |w5[31:16];
    w4 = top_idx[4] ? w5[31:16] : w5[15:0];
    top_idx[3] = |w4[15:8];
    w3 = top_idx[3] ? w4[15:8] : w4[7:0];
    top_idx[2] = |w3[7:4];
    w2 = top_idx[2] ? w3[7:4] : w3[3:0];
    top_idx[1] = |w2[3:2];
    w1 = top_idx[1] ? w2[3] : w2[1];
    top_idx[0] = w1;
  end

  assign highest_next = (|bits_next) ? {1'b0, top_idx} : NO_NOTE;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits  <= '0;
      count <= '0;
    end else begin
      bits  <= bits_next;
      count <= count_next;
    end
  end

endmodule

// ===== verif/note_tracker_checker.sv =====
// Checker for the MIDI note event tracker: predicts every result beat and compares it.
module note_tracker_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mnet_pkg::ADDR_W-1:0] paddr,
  input  logic [mnet_pkg::DATA_W-1:0] pwdata,
  input  logic [mnet_pkg::DATA_W-1:0] prdata,
  input  logic                        pready,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [7:0]                  status_byte,
  input  logic [6:0]                  note_number,
  input  logic [6:0]                  velocity,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        drum_hit,
  input  logic [1:0]                  drum_voice,
  input  logic [31:0]                 drum_voice_count,
  input  logic [31:0]                 drum_total_count,
  input  logic [2:0]                  track_note_on_mask,
  input  logic signed [7:0]           highest_note_1,
  input  logic signed [7:0]           highest_note_2,
  input  logic signed [7:0]           highest_note_3,
  input  logic [31:0]                 note_on_count_1,
  input  logic [31:0]                 note_on_count_2,
  input  logic [31:0]                 note_on_count_3,
  output int                          fails,
  output int                          pending,
  output int                          results,
  output int                          drum_hits,
  output int                          track_note_ons
);
  timeunit 1ns;
  timeprecision 1ps;
  import mnet_pkg::*;

  typedef struct packed {
    logic                             hit;
    logic [1:0]                       voice;
    logic [31:0]                      voice_count;
    logic [31:0]                      total_count;
    logic [NUM_TRACKS-1:0]            on_mask;
    logic [NUM_TRACKS-1:0][7:0]       top_note;
    logic [NUM_TRACKS-1:0][31:0]      on_count;
  } tracker_result_t;

  logic [NOTE_COUNT-1:0] held [NUM_TRACKS];
  logic [31:0]           voice_hits [NUM_DRUM_VOICES];
  logic [31:0]           total_hits;
  logic [31:0]           note_ons [NUM_TRACKS];
  logic [CH_W-1:0]       drum_ch [NUM_DRUM_VOICES];
  logic [CH_W-1:0]       mel_ch [NUM_TRACKS];
  tracker_result_t       result_q [$];

  function automatic logic [7:0] top_held(input logic [NOTE_COUNT-1:0] bits);
    for (int n = NOTE_COUNT - 1; n >= 0; n--) begin
      if (bits[n]) return 8'(n);
    end
    return NO_NOTE;
  endfunction

  function automatic logic [CH_W-1:0] reg_value(input reg_idx_t idx);
    if (idx >= REG_MEL_CH1 && idx <= REG_MEL_CH3) return mel_ch[idx - REG_MEL_CH1];
    if (idx <= REG_DRUM_CH3) return drum_ch[idx - REG_DRUM_CH0];
    return '0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fails++;
    $display("%0t: %s is %0h, predicted %0h", $time, what, got, want);
  endtask

  // Applies one message to the tracker state and returns the result it should produce.
  task automatic apply_message(input logic [7:0] status, input logic [6:0] note,
                               input logic [6:0] vel, output tracker_result_t r);
    logic [3:0]      kind;
    logic [CH_W-1:0] ch;
    logic            is_on;
    logic            is_off;
    kind   = status[7:4];
    ch     = {1'b0, status[3:0]} + 5'd1;
    is_on  = (kind == KIND_NOTE_ON) && (vel != 0);
    is_off = (kind == KIND_NOTE_OFF) || ((kind == KIND_NOTE_ON) && (vel == 0));
    r = '0;
    if (is_on) begin
      // Drum voices have distinct notes, so the first match is the only one.
      for (int v = 0; v < NUM_DRUM_VOICES; v++) begin
        if (!r.hit && ch == drum_ch[v] && note == 7'(DRUM_BASE_NOTE + 2 * v)) begin
          voice_hits[v] = voice_hits[v] + 1;
          total_hits    = total_hits + 1;
          r.hit         = 1'b1;
          r.voice       = 2'(v);
          r.voice_count = voice_hits[v];
        end
      end
    end
    if (!r.hit) begin
      for (int t = 0; t < NUM_TRACKS; t++) begin
        if (ch == mel_ch[t]) begin
          if (is_on) begin
            held[t][note] = 1'b1;
            note_ons[t]   = note_ons[t] + 1;
            r.on_mask[t]  = 1'b1;
          end else if (is_off) begin
            held[t][note] = 1'b0;
          end
        end
      end
    end
    r.total_count = total_hits;
    for (int t = 0; t < NUM_TRACKS; t++) begin
      r.top_note[t] = top_held(held[t]);
      r.on_count[t] = note_ons[t];
    end
  endtask

  always @(posedge clk) begin : watch
    tracker_result_t want;
    tracker_result_t got;
    reg_idx_t        ridx;
    if (rst) begin
      for (int t = 0; t < NUM_TRACKS; t++) begin
        held[t]     = '0;
        note_ons[t] = '0;
        mel_ch[t]   = CH_W'(t + 2);
      end
      for (int v = 0; v < NUM_DRUM_VOICES; v++) begin
        voice_hits[v] = '0;
        drum_ch[v]    = DRUM_CH_RESET;
      end
      total_hits = '0;
      result_q.delete();
      fails          = 0;
      results        = 0;
      drum_hits      = 0;
      track_note_ons = 0;
    end else begin
      if (psel && penable && pready) begin
        ridx = reg_idx_t'(paddr[ADDR_W-1:2]);
        if (!pwrite) begin
          if (prdata !== DATA_W'(reg_value(ridx))) begin
            report_mismatch($sformatf("prdata of register %s", ridx.name()), prdata,
                            DATA_W'(reg_value(ridx)));
          end
        end else if (ridx >= REG_MEL_CH1 && ridx <= REG_MEL_CH3) begin
          mel_ch[ridx - REG_MEL_CH1] = pwdata[CH_W-1:0];
        end else if (ridx <= REG_DRUM_CH3) begin
          drum_ch[ridx - REG_DRUM_CH0] = pwdata[CH_W-1:0];
        end
      end

      if (out_valid && !out_stall) begin
        got.hit         = drum_hit;
        got.voice       = drum_voice;
        got.voice_count = drum_voice_count;
        got.total_count = drum_total_count;
        got.on_mask     = track_note_on_mask;
        got.top_note    = {highest_note_3, highest_note_2, highest_note_1};
        got.on_count    = {note_on_count_3, note_on_count_2, note_on_count_1};
        results++;
        drum_hits      += got.hit;
        track_note_ons += $countones(got.on_mask);
        if (result_q.size() == 0) begin
          report_mismatch("result beat with nothing pending, drum_total_count",
                          got.total_count, '0);
        end else begin
          want = result_q.pop_front();
          if (got.hit !== want.hit) report_mismatch("drum_hit", got.hit, want.hit);
          if (got.voice !== want.voice) report_mismatch("drum_voice", got.voice, want.voice);
          if (got.voice_count !== want.voice_count)
            report_mismatch("drum_voice_count", got.voice_count, want.voice_count);
          if (got.total_count !== want.total_count)
            report_mismatch("drum_total_count", got.total_count, want.total_count);
          if (got.on_mask !== want.on_mask)
            report_mismatch("track_note_on_mask", got.on_mask, want.on_mask);
          for (int t = 0; t < NUM_TRACKS; t++) begin
            if (got.top_note[t] !== want.top_note[t])
              report_mismatch($sformatf("highest_note_%0d", t + 1), got.top_note[t],
                              want.top_note[t]);
            if (got.on_count[t] !== want.on_count[t])
              report_mismatch($sformatf("note_on_count_%0d", t + 1), got.on_count[t],
                              want.on_count[t]);
          end
        end
      end

      if (in_valid && !in_stall) begin
        apply_message(status_byte, note_number, velocity, want);
        result_q.push_back(want);
      end
    end
    pending = result_q.size();
  end

endmodule

// ===== verif/midi_note_event_tracker_unit_tb.sv =====
// Testbench top for the MIDI note event tracker: clock, reset, stimulus and verdict.
module midi_note_event_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mnet_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 120;
  localparam int BLOCK_ITEMS = 40;
  localparam int NUM_PHASES  = 5;

  localparam logic [3:0] KIND_NONE       = 4'h0;
  localparam logic [3:0] KIND_CONTROL    = 4'hB;
  localparam logic [3:0] KIND_PITCH_BEND = 4'hE;
  localparam logic [3:0] KIND_SYSTEM     = 4'hF;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         status_byte;
  logic [6:0]         note_number;
  logic [6:0]         velocity;
  logic               out_valid;
  logic               out_stall;
  logic               drum_hit;
  logic [1:0]         drum_voice;
  logic [31:0]        drum_voice_count;
  logic [31:0]        drum_total_count;
  logic [2:0]         track_note_on_mask;
  logic signed [7:0]  highest_note_1;
  logic signed [7:0]  highest_note_2;
  logic signed [7:0]  highest_note_3;
  logic [31:0]        note_on_count_1;
  logic [31:0]        note_on_count_2;
  logic [31:0]        note_on_count_3;
  int                 fails;
  int                 pending;
  int                 results;
  int                 drum_hits;
  int                 track_note_ons;

  logic [CH_W-1:0] drum_set [NUM_DRUM_VOICES];
  logic [CH_W-1:0] mel_set [NUM_TRACKS];
  int              tx_idle_max;
  int              rx_idle_max;
  int              settings_used;
  int              stalled_cycles;
  int              quiet_cycles;
  bit              hold_req;

  midi_note_event_tracker_unit dut (.*);
  note_tracker_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Channels outside 1..16 cannot be encoded in a status byte; any nibble will do then.
  function automatic logic [7:0] status_of(input logic [3:0] kind, input logic [CH_W-1:0] ch);
    if (ch >= 1 && ch <= 16) return {kind, 4'(ch - 5'd1)};
    return {kind, 4'($urandom)};
  endfunction

  function automatic logic [6:0] pick_note();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd47;
      2: return 7'd48;
      3: return 7'd55;
      4: return 7'd60;
      5: return 7'd61;
      6: return 7'd100;
      7: return 7'd127;
      default: return 7'($urandom);
    endcase
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 11;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] random_channel();
    if ($urandom_range(0, 7) == 0) return CH_W'($urandom);
    return CH_W'($urandom_range(1, 16));
  endfunction

  task automatic apb_access(input bit wr, input reg_idx_t idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_channels(input bit do_write);
    if (do_write) begin
      for (int i = 0; i < NUM_DRUM_VOICES; i++)
        apb_access(1'b1, reg_idx_t'(REG_DRUM_CH0 + i), DATA_W'(drum_set[i]));
      for (int i = 0; i < NUM_TRACKS; i++)
        apb_access(1'b1, reg_idx_t'(REG_MEL_CH1 + i), DATA_W'(mel_set[i]));
    end
    for (int i = 0; i < NUM_DRUM_VOICES; i++)
      apb_access(1'b0, reg_idx_t'(REG_DRUM_CH0 + i), '0);
    for (int i = 0; i < NUM_TRACKS; i++)
      apb_access(1'b0, reg_idx_t'(REG_MEL_CH1 + i), '0);
  endtask

  // Offers one beat after a random gap and returns at the edge where it is taken.
  task automatic drive_beat(input logic [7:0] s, input logic [6:0] n, input logic [6:0] v);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    status_byte <= s;
    note_number <= n;
    velocity    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_beat();
    logic [7:0]      s;
    logic [6:0]      n;
    logic [6:0]      v;
    logic [CH_W-1:0] ch;
    int              r;
    int              t;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      s = status_of(KIND_NOTE_ON, mel_set[$urandom_range(0, NUM_TRACKS - 1)]);
      n = pick_note();
      v = 7'($urandom_range(1, 127));
    end else if (r < 70) begin
      ch = (r < 64) ? mel_set[$urandom_range(0, NUM_TRACKS - 1)]
                    : drum_set[$urandom_range(0, NUM_DRUM_VOICES - 1)];
      s = status_of($urandom_range(0, 1) ? KIND_NOTE_OFF : KIND_NOTE_ON, ch);
      n = pick_note();
      v = (s[7:4] == KIND_NOTE_ON) ? 7'd0 : 7'($urandom);
    end else if (r < 84) begin
      t = $urandom_range(0, NUM_DRUM_VOICES - 1);
      s = status_of(KIND_NOTE_ON, drum_set[t]);
      n = 7'(DRUM_BASE_NOTE + 2 * t);
      v = 7'($urandom_range(1, 127));
    end else begin
      s = 8'($urandom);
      n = 7'($urandom);
      v = 7'($urandom);
    end
    drive_beat(s, n, v);
  endtask

  // Drops valid and waits until every predicted result has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : receiver
    int k;
    out_stall = 1'b0;
    wait (!rst);
    forever begin
      if (hold_req) begin
        k = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        k = $urandom_range(0, rx_idle_max);
      end
      @(negedge clk);
      out_stall <= (k != 0);
      repeat (k) @(negedge clk);
      if (k != 0) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles   <= 0;
      stalled_cycles <= 0;
    end else begin
      if (in_valid && in_stall) stalled_cycles <= stalled_cycles + 1;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    status_byte = '0;
    note_number = '0;
    velocity    = '0;
    tx_idle_max = 11;
    rx_idle_max = 11;
    hold_req    = 1'b0;
    settings_used = 1;
    drum_set = '{default: DRUM_CH_RESET};
    mel_set  = '{5'd2, 5'd3, 5'd4};
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    program_channels(1'b0);

    // Defaults: drums on channel 10, tracks on channels 2, 3 and 4.
    drive_beat(status_of(KIND_NOTE_ON, 5'd10), 7'd48, 7'd127);
    drive_beat(status_of(KIND_NOTE_ON, 5'd10), 7'd50, 7'd1);
    drive_beat(status_of(KIND_NOTE_ON, 5'd10), 7'd52, 7'd64);
    drive_beat(status_of(KIND_NOTE_ON, 5'd10), 7'd54, 7'd127);
    drive_beat(status_of(KIND_NOTE_ON, 5'd10), 7'd49, 7'd100);
    drive_beat(status_of(KIND_NOTE_ON, 5'd10), 7'd48, 7'd0);
    drive_beat(status_of(KIND_NOTE_OFF, 5'd10), 7'd54, 7'd127);
    drive_beat(status_of(KIND_NOTE_ON, 5'd2), 7'd0, 7'd1);
    drive_beat(status_of(KIND_NOTE_ON, 5'd2), 7'd127, 7'd127);
    drive_beat(status_of(KIND_NOTE_ON, 5'd2), 7'd127, 7'd5);
    drive_beat(status_of(KIND_NOTE_ON, 5'd3), 7'd60, 7'd64);
    drive_beat(status_of(KIND_NOTE_ON, 5'd4), 7'd64, 7'd32);
    drive_beat(status_of(KIND_NOTE_ON, 5'd16), 7'd127, 7'd127);
    drive_beat(status_of(KIND_NOTE_OFF, 5'd2), 7'd127, 7'd0);
    drive_beat(status_of(KIND_NOTE_OFF, 5'd2), 7'd5, 7'd64);
    drive_beat(status_of(KIND_NOTE_ON, 5'd3), 7'd60, 7'd0);
    drive_beat(status_of(KIND_CONTROL, 5'd2), 7'd1, 7'd127);
    drive_beat({KIND_SYSTEM, 4'hF}, 7'd127, 7'd127);
    drive_beat({KIND_NONE, 4'h0}, 7'd0, 7'd0);
    drive_beat(status_of(KIND_PITCH_BEND, 5'd4), 7'd64, 7'd0);
    drive_beat(status_of(KIND_NOTE_OFF, 5'd4), 7'd64, 7'd0);
    drive_beat(status_of(KIND_NOTE_OFF, 5'd2), 7'd0, 7'd127);
    drive_beat(status_of(KIND_NOTE_ON, 5'd1), 7'd48, 7'd127);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: begin
          drum_set = '{5'd1, 5'd1, 5'd1, 5'd1};
          mel_set  = '{5'd1, 5'd1, 5'd1};
        end
        2: begin
          // Only voice 0 is reachable; the other drum channels never match.
          drum_set = '{5'd16, 5'd0, 5'd31, 5'd17};
          mel_set  = '{5'd16, 5'd16, 5'd16};
        end
        3: begin
          foreach (drum_set[k]) drum_set[k] = random_channel();
          foreach (mel_set[k]) mel_set[k] = random_channel();
        end
        4: begin
          drum_set = '{5'd3, 5'd4, 5'd5, 5'd6};
          mel_set  = '{5'd2, 5'd2, 5'd3};
        end
        default: ;
      endcase
      if (p != 0) begin
        program_channels(1'b1);
        settings_used++;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % BLOCK_ITEMS == 0) begin
          tx_idle_max = pick_idle();
          rx_idle_max = pick_idle();
        end
        if (p == 2 && i == 60) hold_req = 1'b1;
        random_beat();
      end
      settle();
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d result beats over %0d channel settings: %0d drum hits, %0d note-ons.",
             results, settings_used, drum_hits, track_note_ons);
    $display("The input was held off for %0d cycles by output back-pressure.", stalled_cycles);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
